// ----- src/box_iou_ratio_defines.svh -----
// Assertion macros shared by the box overlap ratio block.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef BOX_IOU_RATIO_DEFINES_SVH
`define BOX_IOU_RATIO_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BIR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BIR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bir_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bir_pkg;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 16;

  // Doubled coordinates: 2*center +/- extent
  localparam int EDGE_BITS    = COORD_BITS + 2;
  localparam int EXT_BITS     = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * COORD_BITS;
  localparam int SUM_BITS     = PROD_BITS + 1;
  localparam int INTER_BITS   = 2 * EXT_BITS;
  localparam int UNION_BITS   = SUM_BITS + 2;
  localparam int RATIO_BITS   = FRAC_BITS + 1;
  localparam int DIV_STEPS    = FRAC_BITS + 1;

  localparam int FRONT_STAGES = 4;
  localparam int QUEUE_DEPTH  = 8;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int CREDIT_BITS  = $clog2(QUEUE_DEPTH + FRONT_STAGES + 1);

  // Edges from start beat to result beat: front, queue write, queue pop, divider
  localparam int LATENCY      = FRONT_STAGES + DIV_STEPS + 2;

  localparam logic [RATIO_BITS-1:0] RATIO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] box_a_center_x;
    logic signed [COORD_BITS-1:0] box_a_center_y;
    logic        [COORD_BITS-1:0] box_a_width;
    logic        [COORD_BITS-1:0] box_a_length;
    logic signed [COORD_BITS-1:0] box_b_center_x;
    logic signed [COORD_BITS-1:0] box_b_center_y;
    logic        [COORD_BITS-1:0] box_b_width;
    logic        [COORD_BITS-1:0] box_b_length;
  } box_pair_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0] overlap_ratio;
    logic                  overlaps;
  } iou_result_t;

  typedef struct packed {
    logic [INTER_BITS-1:0] inter;
    logic [UNION_BITS-1:0] uni;
    logic                  overlaps;
  } div_job_t;

  typedef struct packed {
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } queue_status_t;

endpackage
`default_nettype wire

// ----- src/bir_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bir_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire bir_pkg::box_pair_t boxes,
  output logic [bir_pkg::FRONT_STAGES-1:0] stage_valid,
  output logic                    job_valid,
  output bir_pkg::div_job_t       job
);
  import bir_pkg::*;

  function automatic logic signed [EDGE_BITS-1:0] lo_edge(
    input logic signed [COORD_BITS-1:0] c,
    input logic        [COORD_BITS-1:0] w
  );
    lo_edge = $signed({c[COORD_BITS-1], c, 1'b0}) - $signed({2'b00, w});
  endfunction

  function automatic logic signed [EDGE_BITS-1:0] hi_edge(
    input logic signed [COORD_BITS-1:0] c,
    input logic        [COORD_BITS-1:0] w
  );
    hi_edge = $signed({c[COORD_BITS-1], c, 1'b0}) + $signed({2'b00, w});
  endfunction

  // Overlap of two intervals, clamped at zero
  function automatic logic [EXT_BITS-1:0] axis_extent(
    input logic signed [EDGE_BITS-1:0] a_lo,
    input logic signed [EDGE_BITS-1:0] a_hi,
    input logic signed [EDGE_BITS-1:0] b_lo,
    input logic signed [EDGE_BITS-1:0] b_hi
  );
    logic signed [EDGE_BITS-1:0] lo;
    logic signed [EDGE_BITS-1:0] hi;
    logic signed [EDGE_BITS:0]   diff;
    lo   = (a_lo > b_lo) ? a_lo : b_lo;
    hi   = (a_hi < b_hi) ? a_hi : b_hi;
    diff = $signed({hi[EDGE_BITS-1], hi}) - $signed({lo[EDGE_BITS-1], lo});
    axis_extent = (diff > 0) ? diff[EXT_BITS-1:0] : '0;
  endfunction

  logic [FRONT_STAGES-1:0] valid;

  // stage 1: edges and box areas
  logic signed [EDGE_BITS-1:0] ax_lo, ax_hi, bx_lo, bx_hi;
  logic signed [EDGE_BITS-1:0] ay_lo, ay_hi, by_lo, by_hi;
  logic [PROD_BITS-1:0]        prod_a, prod_b;
  // stage 2: overlap extents and area sum
  logic [EXT_BITS-1:0]         dx, dy;
  logic [SUM_BITS-1:0]         area_sum;
  // stage 3: intersection
  logic [INTER_BITS-1:0]       inter;
  logic [SUM_BITS-1:0]         area_sum_d;
  // stage 4: union
  div_job_t                    job_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[FRONT_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    ax_lo  <= lo_edge(boxes.box_a_center_x, boxes.box_a_width);
    ax_hi  <= hi_edge(boxes.box_a_center_x, boxes.box_a_width);
    bx_lo  <= lo_edge(boxes.box_b_center_x, boxes.box_b_width);
    bx_hi  <= hi_edge(boxes.box_b_center_x, boxes.box_b_width);
    ay_lo  <= lo_edge(boxes.box_a_center_y, boxes.box_a_length);
    ay_hi  <= hi_edge(boxes.box_a_center_y, boxes.box_a_length);
    by_lo  <= lo_edge(boxes.box_b_center_y, boxes.box_b_length);
    by_hi  <= hi_edge(boxes.box_b_center_y, boxes.box_b_length);
    prod_a <= boxes.box_a_width * boxes.box_a_length;
    prod_b <= boxes.box_b_width * boxes.box_b_length;

    dx       <= axis_extent(ax_lo, ax_hi, bx_lo, bx_hi);
    dy       <= axis_extent(ay_lo, ay_hi, by_lo, by_hi);
    area_sum <= {1'b0, prod_a} + {1'b0, prod_b};

    inter      <= dx * dy;
    area_sum_d <= area_sum;

    // Doubled units quadruple both areas; the intersection is already quadrupled
    job_reg.inter    <= inter;
    job_reg.uni      <= {area_sum_d, 2'b00} - {{(UNION_BITS-INTER_BITS){1'b0}}, inter};
    job_reg.overlaps <= (inter != '0);
  end

  assign stage_valid = valid;
  assign job_valid   = valid[FRONT_STAGES-1];
  assign job         = job_reg;

endmodule
`default_nettype wire

// ----- src/bir_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bir_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire bir_pkg::div_job_t     wr_data,
  input  wire logic                  pop,
  output bir_pkg::div_job_t          rd_data,
  output bir_pkg::queue_status_t     status
);
  import bir_pkg::*;

  div_job_t             entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    ptr_inc = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rd_data      = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.count = count;

endmodule
`default_nettype wire

// ----- src/bir_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bir_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire bir_pkg::div_job_t job,
  output logic                   done,
  output bir_pkg::iou_result_t   result
);
  import bir_pkg::*;

  // One quotient bit per stage, restoring division
  logic                  valid [DIV_STEPS+1];
  logic [UNION_BITS-1:0] rem   [DIV_STEPS+1];
  logic [UNION_BITS-1:0] den   [DIV_STEPS+1];
  logic [RATIO_BITS-1:0] quo   [DIV_STEPS+1];
  logic                  nz    [DIV_STEPS+1];

  logic [UNION_BITS:0]   trial    [DIV_STEPS];
  logic [UNION_BITS:0]   diff     [DIV_STEPS];
  logic                  ge       [DIV_STEPS];
  logic [UNION_BITS-1:0] rem_next [DIV_STEPS];

  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      // first step compares the numerator as is, the rest shift left first
      trial[i]    = (i == 0) ? {1'b0, rem[i]} : {rem[i], 1'b0};
      diff[i]     = trial[i] - {1'b0, den[i]};
      ge[i]       = (trial[i] >= {1'b0, den[i]});
      rem_next[i] = ge[i] ? diff[i][UNION_BITS-1:0] : trial[i][UNION_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= {{(UNION_BITS-INTER_BITS){1'b0}}, job.inter};
    den[0] <= job.uni;
    quo[0] <= '0;
    nz[0]  <= job.overlaps;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem[i+1] <= rem_next[i];
      den[i+1] <= den[i];
      quo[i+1] <= {quo[i][RATIO_BITS-2:0], ge[i]};
      nz[i+1]  <= nz[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        valid[i] <= 1'b0;
      end
    end else begin
      valid[0] <= load;
      for (int i = 0; i < DIV_STEPS; i++) begin
        valid[i+1] <= valid[i];
      end
    end
  end

  // No intersection (including an empty union) reads as a ratio of zero
  assign done                 = valid[DIV_STEPS];
  assign result.overlap_ratio = nz[DIV_STEPS] ? quo[DIV_STEPS] : '0;
  assign result.overlaps      = nz[DIV_STEPS];

endmodule
`default_nettype wire

// ----- src/box_iou_ratio.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one box pair per cycle, sustained; the divider pipeline sets the depth.
// Results go out as one-cycle done strobes, in start order; the receiver cannot stall.
// Reset: synchronous, active high; clears all valid bits and queue pointers, busy is high
// while rst is asserted and start is ignored then.
`include "box_iou_ratio_defines.svh"
module box_iou_ratio (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire bir_pkg::box_pair_t   boxes,
  output logic                      busy,
  output logic                      done,
  output bir_pkg::iou_result_t      result
);
  import bir_pkg::*;

  // Front: edges, extents, areas, the intersection and the union, four registered stages.
  // Queue: decouples the front from the divider; the divider pops every beat
  //   it sees, so the queue normally holds at most one entry.
  // Back: pipelined restoring divider, one quotient bit per stage.

  logic                    accept;
  logic [FRONT_STAGES-1:0] front_valid;
  logic                    front_job_valid;
  div_job_t                front_job;
  div_job_t                queue_job;
  queue_status_t           q_status;
  logic                    pop;
  logic [CREDIT_BITS-1:0]  credit;

  // Hold off start during reset, or when the queue could not absorb every beat in flight
  assign credit = CREDIT_BITS'(q_status.count) + CREDIT_BITS'($countones(front_valid));
  assign busy   = rst || (credit >= CREDIT_BITS'(QUEUE_DEPTH));
  assign accept = start && !busy;

  bir_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .boxes       (boxes),
    .stage_valid (front_valid),
    .job_valid   (front_job_valid),
    .job         (front_job)
  );

  // Advance the divider whenever the queue has an entry
  assign pop = !q_status.empty;

  bir_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_job_valid),
    .wr_data (front_job),
    .pop     (pop),
    .rd_data (queue_job),
    .status  (q_status)
  );

  bir_div u_div (
    .clk    (clk),
    .rst    (rst),
    .load   (pop),
    .job    (queue_job),
    .done   (done),
    .result (result)
  );

  // Queue never overflows when the front delivers a beat
  `BIR_ASSERT_IMPL(a_queue_room, front_job_valid, q_status.count != QCNT_BITS'(QUEUE_DEPTH), "queue full on push")
  // Divider keeps the queue at one entry or fewer
  `BIR_ASSERT_NEXT(a_queue_shallow, !q_status.empty, q_status.count <= QCNT_BITS'(1), "queue backed up")
  // Ratio never exceeds one
  `BIR_ASSERT_IMPL(a_ratio_max, done, result.overlap_ratio <= RATIO_ONE, "ratio above one")
  // Every start beat gives exactly one result beat at a fixed distance
  `BIR_ASSERT_IMPL(a_fixed_latency, 1'b1, done == $past(start && !busy, LATENCY), "result beat out of step")

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import bir_pkg::*;

  // One box pair waiting to be driven, with the idle odds of its phase and a flag
  // that holds it back until the pipe has drained.
  typedef struct {
    box_pair_t   pair;
    int unsigned idle_pct;
    bit          wait_drain;
  } pair_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  box_pair_t   boxes = '0;
  logic        busy;
  logic        done;
  iou_result_t result;

  pair_beat_t  pending_pairs[$];
  iou_result_t iou_expect[$];
  int unsigned mismatches = 0;
  bit          beat_taken;
  iou_result_t want;

  box_iou_ratio dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .boxes  (boxes),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Overlap along one axis in doubled units: [2c-w, 2c+w] against [2c-w, 2c+w],
  // clamped at zero when the spans only touch or miss each other.
  function automatic longint span_overlap(longint ca, longint wa, longint cb, longint wb);
    longint lo;
    longint hi;
    lo = (2 * ca - wa > 2 * cb - wb) ? 2 * ca - wa : 2 * cb - wb;
    hi = (2 * ca + wa < 2 * cb + wb) ? 2 * ca + wa : 2 * cb + wb;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Expected IoU beat for one box pair. All areas carry the same factor of four,
  // so it cancels in the ratio. A zero union or a zero intersection gives 0.
  function automatic iou_result_t iou_predict(box_pair_t p);
    longint      ovl_x;
    longint      ovl_y;
    bit [63:0]   inter;
    bit [63:0]   area_a;
    bit [63:0]   area_b;
    bit [63:0]   uni;
    bit [63:0]   ratio;
    iou_result_t r;
    ovl_x  = span_overlap(longint'($signed(p.box_a_center_x)), longint'(p.box_a_width),
                          longint'($signed(p.box_b_center_x)), longint'(p.box_b_width));
    ovl_y  = span_overlap(longint'($signed(p.box_a_center_y)), longint'(p.box_a_length),
                          longint'($signed(p.box_b_center_y)), longint'(p.box_b_length));
    inter  = 64'(ovl_x) * 64'(ovl_y);
    area_a = (64'(p.box_a_width) * 2) * (64'(p.box_a_length) * 2);
    area_b = (64'(p.box_b_width) * 2) * (64'(p.box_b_length) * 2);
    uni    = area_a + area_b - inter;
    ratio  = 0;
    // Intersection never exceeds the union, so the quotient fits in Q1.16.
    if (uni != 0 && inter != 0) ratio = (inter << FRAC_BITS) / uni;
    r.overlap_ratio = ratio[RATIO_BITS-1:0];
    r.overlaps      = (inter != 0);
    return r;
  endfunction

  // Extents spread over all magnitudes, down to zero.
  function automatic logic [COORD_BITS-1:0] random_extent();
    logic [31:0] v;
    v = $urandom_range(0, 65535) >> $urandom_range(0, COORD_BITS);
    return v[COORD_BITS-1:0];
  endfunction

  function automatic box_pair_t mk_pair(int cax, int cay, int aw, int al,
                                        int cbx, int cby, int bw, int bl);
    box_pair_t p;
    p.box_a_center_x = cax[COORD_BITS-1:0];
    p.box_a_center_y = cay[COORD_BITS-1:0];
    p.box_a_width    = aw[COORD_BITS-1:0];
    p.box_a_length   = al[COORD_BITS-1:0];
    p.box_b_center_x = cbx[COORD_BITS-1:0];
    p.box_b_center_y = cby[COORD_BITS-1:0];
    p.box_b_width    = bw[COORD_BITS-1:0];
    p.box_b_length   = bl[COORD_BITS-1:0];
    return p;
  endfunction

  // Mostly pairs that actually overlap, since fully random boxes almost never do;
  // the rest are nested, touching, degenerate or plain random pairs.
  function automatic box_pair_t random_pair();
    box_pair_t   p;
    int unsigned kind;
    int          reach;
    int          ca;
    kind = $urandom_range(0, 99);
    p = mk_pair($urandom, $urandom, random_extent(), random_extent(),
                $urandom, $urandom, random_extent(), random_extent());
    if (kind < 60) begin
      // Place box b within overlap reach of box a on both axes.
      reach = (int'(p.box_a_width) + int'(p.box_b_width)) / 2 + 1;
      ca    = int'(p.box_a_center_x);
      p.box_b_center_x = COORD_BITS'(ca + int'($urandom_range(0, 2 * reach)) - reach);
      reach = (int'(p.box_a_length) + int'(p.box_b_length)) / 2 + 1;
      ca    = int'(p.box_a_center_y);
      p.box_b_center_y = COORD_BITS'(ca + int'($urandom_range(0, 2 * reach)) - reach);
    end else if (kind < 70) begin
      // Same box, or a box shrunk around the same center.
      p.box_b_center_x = p.box_a_center_x;
      p.box_b_center_y = p.box_a_center_y;
      p.box_b_width    = p.box_a_width >> ((kind < 65) ? $urandom_range(0, 3) : 0);
      p.box_b_length   = p.box_a_length >> ((kind < 65) ? $urandom_range(0, 3) : 0);
    end else if (kind >= 85 && kind < 95) begin
      // Edges meet exactly along x; match parity so the doubled edges line up.
      p.box_b_width[0] = p.box_a_width[0];
      reach = (int'(p.box_a_width) + int'(p.box_b_width)) / 2;
      ca    = int'(p.box_a_center_x);
      p.box_b_center_x = $urandom_range(0, 1) ? COORD_BITS'(ca + reach)
                                              : COORD_BITS'(ca - reach);
      p.box_b_center_y = p.box_a_center_y;
    end else if (kind >= 95) begin
      // Degenerate extents: each one set to zero at random.
      if ($urandom_range(0, 1)) p.box_a_width = '0;
      if ($urandom_range(0, 1)) p.box_a_length = '0;
      if ($urandom_range(0, 1)) p.box_b_width = '0;
      if ($urandom_range(0, 1)) p.box_b_length = '0;
    end
    return p;
  endfunction

  task automatic queue_pair(box_pair_t p, int unsigned idle_pct, bit wait_drain);
    pair_beat_t b;
    b.pair       = p;
    b.idle_pct   = idle_pct;
    b.wait_drain = wait_drain;
    pending_pairs = {pending_pairs, b};
  endtask

  // Driver: at each rising edge retire the beat the block just took, then offer
  // the next pair, idle, or hold the current start until busy drops.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      beat_taken = start && !busy;
      if (beat_taken) begin
        iou_expect = {iou_expect, iou_predict(boxes)};
        void'(pending_pairs.pop_front());
      end
      // An offered pair stays on the port until it is taken.
      if (!start || beat_taken) begin
        if (pending_pairs.size() != 0 &&
            !(pending_pairs[0].wait_drain && iou_expect.size() != 0) &&
            $urandom_range(0, 99) >= pending_pairs[0].idle_pct) begin
          start <= 1'b1;
          boxes <= pending_pairs[0].pair;
        end else begin
          // Idle: drop start and put junk on the payload.
          start <= 1'b0;
          boxes <= random_pair();
        end
      end
    end
  end

  // Monitor: every done strobe is one result beat; match it against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (iou_expect.size() == 0) begin
        $error("result beat with no pair outstanding: overlap_ratio %0d overlaps %0d",
               result.overlap_ratio, result.overlaps);
        mismatches++;
      end else begin
        want = iou_expect.pop_front();
        if (result.overlap_ratio !== want.overlap_ratio) begin
          $error("overlap_ratio: expected %0d, actual %0d",
                 want.overlap_ratio, result.overlap_ratio);
          mismatches++;
        end
        if (result.overlaps !== want.overlaps) begin
          $error("overlaps: expected %0d, actual %0d", want.overlaps, result.overlaps);
          mismatches++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned phase_idle[3] = '{0, 83, 18};
    // Directed pairs, back to back.
    queue_pair(mk_pair(0, 0, 10, 10, 0, 0, 10, 10), 0, 0);           // identical boxes
    queue_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 0, 0);               // zero union
    queue_pair(mk_pair(100, -100, 0, 0, -5, 7, 0, 0), 0, 0);         // zero union, apart
    queue_pair(mk_pair(0, 0, 0, 10, 0, 0, 10, 10), 0, 0);            // zero-width box a
    queue_pair(mk_pair(0, 0, 10, 10, 0, 0, 10, 0), 0, 0);            // zero-length box b
    queue_pair(mk_pair(0, 0, 65535, 0, 0, 0, 0, 65535), 0, 0);       // two flat boxes
    queue_pair(mk_pair(0, 0, 10, 10, 10, 0, 10, 10), 0, 0);          // touching along x
    queue_pair(mk_pair(0, 0, 10, 10, 0, -10, 10, 10), 0, 0);         // touching along y
    queue_pair(mk_pair(0, 0, 10, 10, 50, 50, 10, 10), 0, 0);         // disjoint
    queue_pair(mk_pair(0, 0, 10, 10, 3, 2, 10, 10), 0, 0);           // partial overlap
    queue_pair(mk_pair(0, 0, 100, 100, 5, 5, 10, 10), 0, 0);         // b inside a
    queue_pair(mk_pair(0, 0, 3, 3, 1, 1, 3, 3), 0, 0);               // odd extents
    queue_pair(mk_pair(0, 0, 1, 1, 0, 0, 1, 1), 0, 0);               // unit boxes
    queue_pair(mk_pair(-1, -1, 2, 2, 0, 0, 2, 2), 0, 0);
    queue_pair(mk_pair(-32768, -32768, 65535, 65535,
                       -32768, -32768, 65535, 65535), 0, 0);         // identical, largest
    queue_pair(mk_pair(32767, 32767, 65535, 65535,
                       -32768, -32768, 65535, 65535), 0, 0);         // opposite corners
    queue_pair(mk_pair(-32768, 0, 65535, 65535, 32767, 0, 65535, 65535), 0, 0);
    queue_pair(mk_pair(32767, -32768, 65535, 1, 32767, -32768, 1, 65535), 0, 0); // cross
    queue_pair(mk_pair(32767, 32767, 65535, 65535, 32767, 32767, 1, 1), 0, 0);
    queue_pair(mk_pair(-32768, 32767, 1, 65535, -32768, 32767, 65535, 1), 0, 0);
    // Random phases: no idling, heavy sender idling, light sender idling. The first
    // pair of each phase waits for the pipe to drain, and so does one mid-phase.
    foreach (phase_idle[ph]) begin
      for (int i = 0; i < 350; i++)
        queue_pair(random_pair(), phase_idle[ph], (i == 0) || (i == 175));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain: all pairs taken, all results back, then a tail for stray beats.
    while (pending_pairs.size() != 0 || iou_expect.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (iou_expect.size() == 0 && mismatches == 0)
      $display("[box_iou_ratio] OK");
    else
      $display("[box_iou_ratio] ERROR");
    $finish;
  end

  // Watchdog.
  initial begin
    #3_000_000;
    $display("[box_iou_ratio] ERROR");
    $finish;
  end

endmodule
